>>> sv/gte_pkg.sv
package gte_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CosW    = 17;
  localparam int unsigned ProdW   = CosW + SampleW;
  localparam int unsigned EnergyW = 33;
  localparam int unsigned AccW    = EnergyW + 1;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_UPD,
    ST_FMUL,
    ST_FRND,
    ST_SQ1,
    ST_SQ2,
    ST_MS,
    ST_FIN
  } gte_state_e;

  // Operand pairs of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_C_S1,
    MUL_S1_S1,
    MUL_S2_S2,
    MUL_M_S2
  } gte_mul_sel_e;

  typedef struct packed {
    logic         cap_en;
    logic         mul_en;
    gte_mul_sel_e mul_sel;
    logic         m_en;
    logic         upd_en;
    logic         acc_load;
    logic         acc_add;
    logic         out_load;
  } gte_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } gte_status_t;

endpackage

>>> sv/gte_if.sv
// Input channel: one sample and its end-of-block flag.
interface gte_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Output channel: one energy value per block.
interface gte_out_if;
  logic                valid;
  logic                ready;
  logic signed [32:0]  energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

>>> sv/gte_ctrl.sv
module gte_ctrl
  import gte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  gte_status_t status_i,
  output gte_cmd_t    cmd_o
);

  gte_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_RND;
      ST_RND:  state_d = ST_UPD;
      ST_UPD:  state_d = status_i.last ? ST_FMUL : ST_IDLE;
      ST_FMUL: state_d = ST_FRND;
      ST_FRND: state_d = ST_SQ1;
      ST_SQ1:  state_d = ST_SQ2;
      ST_SQ2:  state_d = ST_MS;
      ST_MS:   state_d = ST_FIN;
      ST_FIN: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_C_S1;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.cap_en = in_valid_i;
      end
      ST_MUL:  cmd_o.mul_en = 1'b1;
      ST_RND:  cmd_o.m_en   = 1'b1;
      ST_UPD:  cmd_o.upd_en = 1'b1;
      ST_FMUL: cmd_o.mul_en = 1'b1;
      ST_FRND: cmd_o.m_en   = 1'b1;
      ST_SQ1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_S1_S1;
      end
      ST_SQ2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_S2_S2;
        cmd_o.acc_load = 1'b1;
      end
      ST_MS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_M_S2;
        cmd_o.acc_add = 1'b1;
      end
      ST_FIN:  cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/gte_datapath.sv
module gte_datapath
  import gte_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic signed [CosW-1:0]     cfg_data_i,
  input  logic signed [SampleW-1:0]  sample_i,
  input  logic                       last_i,
  input  gte_cmd_t                   cmd_i,
  output gte_status_t                status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [EnergyW-1:0]  out_energy_o
);

  // Clamp a 20-bit value to the signed 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // The product c*s1 doubled and shifted by 15 is the product shifted by 14.
  // Round half to even, then clamp.
  function automatic logic signed [15:0] round_sat(input logic signed [ProdW-1:0] p);
    logic signed [18:0] q;
    logic [13:0]        r;
    logic signed [19:0] qr;
    q  = p[ProdW-1:14];
    r  = p[13:0];
    qr = {q[18], q};
    if (r > 14'h2000 || (r == 14'h2000 && q[0])) begin
      qr = qr + 20'sd1;
    end
    return sat16(qr);
  endfunction

  logic signed [CosW-1:0]    cos_q;
  logic signed [SampleW-1:0] x_q;
  logic                      last_q;
  logic signed [SampleW-1:0] s1_q, s2_q, m_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      out_valid_q;
  logic signed [EnergyW-1:0] out_q;

  logic signed [CosW-1:0]    op_a;
  logic signed [SampleW-1:0] op_b;
  logic signed [19:0]        sum;
  logic signed [AccW-1:0]    prod_ext;
  logic signed [AccW-1:0]    energy;

  // Cosine register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= '0;
    end else if (cfg_we_i) begin
      cos_q <= cfg_data_i;
    end
  end

  // Input capture at the transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      x_q    <= sample_i;
      last_q <= last_i;
    end
  end

  // Shared multiplier operand select and product register.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_C_S1: begin
        op_a = cos_q;
        op_b = s1_q;
      end
      MUL_S1_S1: begin
        op_a = {s1_q[SampleW-1], s1_q};
        op_b = s1_q;
      end
      MUL_S2_S2: begin
        op_a = {s2_q[SampleW-1], s2_q};
        op_b = s2_q;
      end
      default: begin
        op_a = {m_q[SampleW-1], m_q};
        op_b = s2_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.m_en) begin
      m_q <= round_sat(prod_q);
    end
  end

  // Recursion update and the end-of-block clear.
  assign sum = {{4{x_q[SampleW-1]}}, x_q} + {{4{m_q[SampleW-1]}}, m_q}
             - {{4{s2_q[SampleW-1]}}, s2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (cmd_i.out_load) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (cmd_i.upd_en) begin
      s2_q <= s1_q;
      s1_q <= sat16(sum);
    end
  end

  // Energy accumulator.
  assign prod_ext = {prod_q[ProdW-1], prod_q};
  assign energy   = acc_q - prod_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      acc_q <= prod_ext;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_ext;
    end
  end

  // Output register; the next block may start while it waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= energy[EnergyW-1:0];
    end
  end

  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_energy_o      = out_q;

endmodule

>>> sv/goertzel_tone_energy.sv
// Goertzel tone energy detector, Q15 coefficient, one shared 17x16 multiplier.
// Each sample passes transfer, multiply, round and update before the next is taken.
// A sample marked last then runs FMUL, FRND, SQ1, SQ2, MS and FIN for the energy,
// which the same multiplier forms in four products; FIN waits for a free output.
// Reset (rst_ni low, asynchronous) clears the cosine, both delays and output valid.
module goertzel_tone_energy
  import gte_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic signed [CosW-1:0]  cfg_data_i,
  gte_in_if.sink                  in_i,
  gte_out_if.source               out_o
);

  gte_cmd_t    cmd;
  gte_status_t status;

  gte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gte_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (in_i.sample),
    .last_i       (in_i.last),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_energy_o (out_o.energy)
  );

endmodule

>>> verif/gte_energy_checker.sv
// Watches both channels and the cosine register, runs its own Goertzel
// recursion on every accepted sample and compares each energy transfer
// against the oldest predicted value.
module gte_energy_checker
  import gte_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic signed [CosW-1:0]    cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic                      in_last_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [EnergyW-1:0] out_energy_i,
  output int                        errors_o,
  output int                        energy_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SatMax  = 32767;
  localparam longint SatMin  = -32768;
  localparam longint HalfLsb = 16384;
  localparam longint FracMsk = 32767;

  logic signed [CosW-1:0]    cosine;
  logic signed [SampleW-1:0] delay_one;
  logic signed [SampleW-1:0] delay_two;
  logic signed [EnergyW-1:0] expected_energy [$];

  initial errors_o = 0;

  // Clip a wide value to the signed 16-bit range.
  function automatic logic signed [SampleW-1:0] clip16(input longint v);
    if (v > SatMax) return SampleW'(SatMax);
    if (v < SatMin) return SampleW'(SatMin);
    return SampleW'(v);
  endfunction

  // 2*c*s scaled down by 2^15, ties to even, then clipped to 16 bits.
  function automatic logic signed [SampleW-1:0] cos_product(
    input logic signed [CosW-1:0]    c,
    input logic signed [SampleW-1:0] s
  );
    longint p;
    longint q;
    longint frac;
    p    = 2 * longint'(c) * longint'(s);
    q    = p >>> 15;
    frac = p & FracMsk;
    if (frac > HalfLsb || (frac == HalfLsb && q[0])) q++;
    return clip16(q);
  endfunction

  // One recursion step; a sample marked last also queues the block energy.
  function automatic void advance_recursion(
    input logic signed [SampleW-1:0] x,
    input logic                      blk_end
  );
    logic signed [SampleW-1:0] m;
    logic signed [SampleW-1:0] s0;
    longint s1;
    longint s2;
    longint mf;
    longint e;
    logic signed [EnergyW-1:0] e_cut;
    m         = cos_product(cosine, delay_one);
    s0        = clip16(longint'(x) + longint'(m) - longint'(delay_two));
    delay_two = delay_one;
    delay_one = s0;
    if (blk_end) begin
      s1 = delay_one;
      s2 = delay_two;
      mf = cos_product(cosine, delay_one);
      e  = s1 * s1 + s2 * s2 - mf * s2;
      e_cut = EnergyW'(e);
      expected_energy = {expected_energy, e_cut};
      delay_one = '0;
      delay_two = '0;
    end
  endfunction

  // Track register writes, predict on sample transfers, check energy transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cosine    = '0;
      delay_one = '0;
      delay_two = '0;
      expected_energy.delete();
    end else begin
      if (cfg_we_i) cosine = cfg_data_i;
      if (in_valid_i && in_ready_i) advance_recursion(in_sample_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_energy.size() == 0) begin
          $display("%0t: energy %0d arrived with nothing expected", $realtime, out_energy_i);
          errors_o++;
        end else begin
          if (out_energy_i !== expected_energy[0]) begin
            $display("%0t: energy mismatch, expected %0d, actual %0d",
                     $realtime, expected_energy[0], out_energy_i);
            errors_o++;
          end
          void'(expected_energy.pop_front());
        end
      end
    end
    energy_pending_o = expected_energy.size();
  end

endmodule

>>> verif/goertzel_tone_energy_tb.sv
// Stimulus and verdict for the Goertzel tone energy block.
module goertzel_tone_energy_tb;
  import gte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 24;
  localparam int DrainCycles  = 40;
  localparam int LongHold     = 250;
  localparam int QuietLimit   = 4000;
  localparam int PhaseItems   = 54;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we;
  logic signed [CosW-1:0] cfg_data;
  int                     error_count;
  int                     energy_left;
  int                     burst_left;
  logic                   gapless;
  logic                   long_hold_req;

  gte_in_if  in_if ();
  gte_out_if out_if ();

  goertzel_tone_energy uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  gte_energy_checker energy_mon (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .in_sample_i      (in_if.sample),
    .in_last_i        (in_if.last),
    .out_valid_i      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_energy_i     (out_if.energy),
    .errors_o         (error_count),
    .energy_pending_o (energy_left)
  );

  always #5 clk = ~clk;

  // Drop valid for a number of cycles.
  task automatic pause_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  // Offer one sample and wait for its transfer; bursts are broken by random gaps unless gapless is set.
  task automatic send(input logic signed [SampleW-1:0] s, input logic blk_end);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!gapless && $urandom_range(0, 3) != 0) pause_input($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.last   <= blk_end;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Load the cosine once every energy is out and the block has gone quiet.
  task automatic set_cosine(input logic signed [CosW-1:0] c);
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (energy_left == 0);
    repeat (SettleCycles) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return SampleW'(int'($urandom_range(0, 511)) - 256);
      default: return SampleW'($urandom);
    endcase
  endfunction

  // Main stimulus: directed blocks, then random phases under several cosines.
  initial begin : stimulus
    logic signed [CosW-1:0] c;
    int blk_len;
    int items;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.last    = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    burst_left    = 0;
    gapless       = 1'b0;
    long_hold_req = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset cosine of zero: single-item block and the most negative sample.
    send(16'sh7fff, 1'b1);
    send(16'sh8000, 1'b0);
    send(16'sh8000, 1'b1);
    send(16'sh0000, 1'b1);

    // Rounding ties: 1.5 and -1.5 go to 2 and -2.
    set_cosine(17'sd3);
    send(16'sd8192, 1'b0);
    send(16'sd0, 1'b1);
    send(-16'sd8192, 1'b0);
    send(16'sd0, 1'b1);

    // A tie of 0.5 rounds down to zero.
    set_cosine(17'sd1);
    send(16'sd8192, 1'b0);
    send(16'sd0, 1'b1);

    // Full-scale cosine drives the product and the new state into clipping.
    set_cosine(17'sd32768);
    send(16'sh7fff, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh7fff, 1'b1);

    // Cosine patterns at both ends of the 17-bit register.
    set_cosine(17'h10000);
    send(16'sh8000, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh8000, 1'b1);
    set_cosine(17'h0ffff);
    send(16'sh7fff, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sd1, 1'b1);

    // Random blocks of mostly short length under a different cosine per phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       c = 17'sd32768;
        1:       c = -17'sd32768;
        2:       c = CosW'(int'($urandom_range(0, 65536)) - 32768);
        4:       c = '0;
        5:       c = 17'sd23170;
        6:       c = 17'h10000;
        default: c = CosW'($urandom);
      endcase
      set_cosine(c);
      gapless       = (ph == 2 || ph == 6);
      long_hold_req = gapless;
      items = 0;
      while (items < PhaseItems) begin
        blk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
        for (int k = 0; k < blk_len; k++) send(rand_sample(), k == blk_len - 1);
        items += blk_len;
      end
      long_hold_req = 1'b0;
      gapless       = 1'b0;
    end

    // Drain and give the verdict.
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (energy_left == 0);
    repeat (DrainCycles) @(negedge clk);
    if (error_count == 0 && energy_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver ready: a changing stall pattern plus a long hold-off on request.
  initial begin : receiver
    int   mode;
    int   mode_left;
    int   hold_left;
    int   run_left;
    logic run_ready;
    logic hold_seen;
    out_if.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    run_left  = 0;
    run_ready = 1'b0;
    hold_seen = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_seen) begin
        hold_left = LongHold;
        hold_seen = 1'b1;
      end
      if (!long_hold_req) hold_seen = 1'b0;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (run_left == 0) begin
              run_ready = ~run_ready;
              run_left  = $urandom_range(1, 20);
            end
            run_left--;
            out_if.ready <= run_ready;
          end
        endcase
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $realtime, QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
